FILE: rtl/core/multi_button_debounce_events_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Shared property wrappers used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCE_EVENTS_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCE_EVENTS_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define MBDE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define MBDE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mbde_pkg.sv
// ---------------------------------------------------------------------------
// Button debounce package
// Item types, configuration layout, register indexes and defaults.
// ---------------------------------------------------------------------------
package mbde_pkg;

    localparam int BUTTONS_DEFAULT     = 8;
    localparam int ACTION_BITS_DEFAULT = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] DEBOUNCE_DELAY_RESET    = 16'd50;
    localparam logic [15:0] INTERRUPT_LOCKOUT_RESET = 16'd200;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_DELAY    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUTTON_COUNT      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_LOW_MASK   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTION_CODES      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERRUPT_ACTION  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERRUPT_LOCKOUT = 3'd5;

    localparam logic OP_INTERRUPT = 1'b0;
    localparam logic OP_POLL      = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] timestamp;
        logic [7:0]  button_levels;
    } t_in_item;

    typedef struct packed {
        logic [3:0] action_code;
        logic       from_interrupt;
        logic [2:0] button_index;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [31:0] timestamp;
        logic [7:0]  button_levels;
        logic        irq_pending;
    } t_poll_cmd;

    typedef struct packed {
        logic [15:0] debounce_delay;
        logic [3:0]  button_count;
        logic [7:0]  active_low_mask;
        logic [31:0] action_codes;
        logic [3:0]  interrupt_action;
        logic [15:0] interrupt_lockout;
    } t_cfg;

endpackage

FILE: rtl/core/multi_button_debounce_events.sv
// ---------------------------------------------------------------------------
// Multi-button debounce with press latch
// Debounces polled buttons and one interrupt button and reports presses.
// ---------------------------------------------------------------------------
// An interrupt item is absorbed by the front end and gives no result. A
// poll item is queued and then occupies the back end while it checks the
// clamped button count, one button per cycle while the output is not
// stalled; output stalls hold the back end. The input side takes one
// item per cycle while the two-entry command queue has room, and results of
// one poll leave in order with last_of_run set on the final one.
module multi_button_debounce_events import mbde_pkg::*; #(
    parameter int BUTTONS     = BUTTONS_DEFAULT,
    parameter int ACTION_BITS = ACTION_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_in_valid,
    input  t_in_item                  i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_data
);

    t_cfg      r_cfg;
    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    t_poll_cmd front_cmd;
    t_poll_cmd back_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_delay    <= DEBOUNCE_DELAY_RESET;
            r_cfg.button_count      <= 4'd0;
            r_cfg.active_low_mask   <= 8'd0;
            r_cfg.action_codes      <= 32'd0;
            r_cfg.interrupt_action  <= 4'd0;
            r_cfg.interrupt_lockout <= INTERRUPT_LOCKOUT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_DELAY:    r_cfg.debounce_delay    <= i_cfg_data[15:0];
                REG_BUTTON_COUNT:      r_cfg.button_count      <= i_cfg_data[3:0];
                REG_ACTIVE_LOW_MASK:   r_cfg.active_low_mask   <= i_cfg_data[7:0];
                REG_ACTION_CODES:      r_cfg.action_codes      <= i_cfg_data[31:0];
                REG_INTERRUPT_ACTION:  r_cfg.interrupt_action  <= i_cfg_data[3:0];
                REG_INTERRUPT_LOCKOUT: r_cfg.interrupt_lockout <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    mbde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    mbde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (back_cmd)
    );

    mbde_back #(
        .BUTTONS     (BUTTONS),
        .ACTION_BITS (ACTION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/core/mbde_front.sv
// ---------------------------------------------------------------------------
// Button debounce front end
// Accepts items, applies the interrupt lockout and queues poll commands.
// ---------------------------------------------------------------------------
module mbde_front import mbde_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    input  logic      i_q_full,
    output logic      o_push,
    output t_poll_cmd o_cmd
);

    logic        r_irq_pending;
    logic [31:0] r_last_irq_time;
    logic        accept;
    logic [31:0] elapsed;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept && (i_in_data.opcode == OP_POLL);
    assign elapsed    = i_in_data.timestamp - r_last_irq_time;

    assign o_cmd.timestamp     = i_in_data.timestamp;
    assign o_cmd.button_levels = i_in_data.button_levels;
    assign o_cmd.irq_pending   = r_irq_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_pending   <= 1'b0;
            r_last_irq_time <= 32'd0;
        end else if (accept) begin
            if (i_in_data.opcode == OP_POLL) begin
                r_irq_pending <= 1'b0;
            end else if (elapsed > 32'(i_cfg.interrupt_lockout)) begin
                r_irq_pending   <= 1'b1;
                r_last_irq_time <= i_in_data.timestamp;
            end
        end
    end

endmodule

FILE: rtl/core/mbde_queue.sv
// ---------------------------------------------------------------------------
// Button debounce command queue
// Small register FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module mbde_queue import mbde_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_poll_cmd i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_poll_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_poll_cmd         r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/mbde_back.sv
// ---------------------------------------------------------------------------
// Button debounce back end
// Steps through the buttons of one poll and emits the resulting items.
// ---------------------------------------------------------------------------
module mbde_back import mbde_pkg::*; #(
    parameter int BUTTONS     = BUTTONS_DEFAULT,
    parameter int ACTION_BITS = ACTION_BITS_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_poll_cmd i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IW   = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CW   = $clog2(BUTTONS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_idx;
    logic [31:0]       r_now;
    logic [7:0]        r_levels;
    logic              r_hold_valid;
    t_out_item         r_hold;
    logic              r_out_valid;
    t_out_item         r_out;
    logic              r_pressed     [BUTTONS];
    logic [31:0]       r_change_time [BUTTONS];
    logic              r_awaiting    [BUTTONS];

    logic [CMPW-1:0]        count_ext;
    logic [CW-1:0]          count;
    logic [IW-1:0]          bi;
    logic [7:0]             idx_ext;
    logic [7:0]             shift;
    logic [31:0]            shifted;
    logic [ACTION_BITS-1:0] act_raw;
    logic [7:0]             act8;
    logic                   lvl;
    logic                   act_low;
    logic                   pressed;
    logic                   stable;
    logic                   emit;
    logic                   out_free;
    logic                   in_range;
    logic                   load_out;
    t_out_item              new_item;
    t_out_item              hold_out;

    assign count_ext = CMPW'(i_cfg.button_count);
    assign count     = (count_ext > CMPW'(BUTTONS)) ? CW'(BUTTONS) : CW'(count_ext);
    assign in_range  = (r_idx < count);
    assign bi        = r_idx[IW-1:0];
    assign idx_ext   = 8'(r_idx);
    assign lvl       = (idx_ext < 8'd8) ? r_levels[idx_ext[2:0]] : 1'b0;
    assign act_low   = (idx_ext < 8'd8) ? i_cfg.active_low_mask[idx_ext[2:0]] : 1'b0;
    assign pressed   = lvl ^ act_low;
    assign stable    = (pressed == r_pressed[bi])
                       && ((r_now - r_change_time[bi]) > 32'(i_cfg.debounce_delay));
    assign emit      = stable && pressed && !r_awaiting[bi];

    assign shift     = 8'(idx_ext * 8'(ACTION_BITS));
    assign shifted   = (shift < 8'd32) ? (i_cfg.action_codes >> shift[4:0]) : 32'd0;
    assign act_raw   = shifted[ACTION_BITS-1:0];
    assign act8      = 8'(act_raw);

    assign new_item.action_code    = act8[3:0];
    assign new_item.from_interrupt = 1'b0;
    assign new_item.button_index   = idx_ext[2:0];
    assign new_item.last_of_run    = 1'b0;

    assign hold_out.action_code    = r_hold.action_code;
    assign hold_out.from_interrupt = r_hold.from_interrupt;
    assign hold_out.button_index   = r_hold.button_index;
    assign hold_out.last_of_run    = !in_range;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign load_out    = (r_state == ST_RUN) && out_free && r_hold_valid
                         && (!in_range || emit);
    assign o_pop       = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < BUTTONS; i++) begin
                r_pressed[i]     <= 1'b0;
                r_change_time[i] <= 32'd0;
                r_awaiting[i]    <= 1'b0;
            end
        end else begin
            if (load_out) begin
                r_out       <= hold_out;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state                    <= ST_RUN;
                        r_idx                      <= '0;
                        r_now                      <= i_cmd.timestamp;
                        r_levels                   <= i_cmd.button_levels;
                        r_hold_valid               <= i_cmd.irq_pending;
                        r_hold.action_code         <= i_cfg.interrupt_action;
                        r_hold.from_interrupt      <= 1'b1;
                        r_hold.button_index        <= 3'd0;
                        r_hold.last_of_run         <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (out_free) begin
                        if (in_range) begin
                            if (pressed != r_pressed[bi]) begin
                                r_change_time[bi] <= r_now;
                            end
                            if (emit) begin
                                r_awaiting[bi] <= 1'b1;
                            end else if (stable && !pressed) begin
                                r_awaiting[bi] <= 1'b0;
                            end
                            r_pressed[bi] <= pressed;
                            if (emit) begin
                                r_hold       <= new_item;
                                r_hold_valid <= 1'b1;
                            end
                            r_idx <= r_idx + CW'(1);
                        end else begin
                            r_hold_valid <= 1'b0;
                            r_state      <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/mbde_checker.sv
// ---------------------------------------------------------------------------
// Button debounce port checker
// Watches the top-level ports of the debounce block and flags misbehavior.
// ---------------------------------------------------------------------------
`include "multi_button_debounce_events_defines.svh"

module mbde_checker import mbde_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    `MBDE_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")
    `MBDE_ASSERT(a_irq_index, i_clk, i_rst_n, o_out_valid && o_out_data.from_interrupt |-> o_out_data.button_index == 3'd0, "interrupt result with nonzero index")
    `MBDE_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `MBDE_ASSERT_ALWAYS(a_reset_in, i_clk, !i_rst_n |=> !o_in_stall, "input stalled after reset")

endmodule

bind multi_button_debounce_events mbde_checker u_mbde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: tb/tb_multi_button_debounce_events.sv
// ---------------------------------------------------------------------------
// Testbench for the multi-button debounce block
// Drives interrupt and poll items through the valid/stall input channel,
// predicts press and interrupt events from a behavioral copy of the debouncer
// state or from a directed table, and compares each result item field by field
// in order. The directed table covers reset values, lockout edges, polarity,
// clamping and timestamp wrap; random phases with changing settings follow.
// ---------------------------------------------------------------------------
module tb_multi_button_debounce_events import mbde_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned PHASES = 7;
    localparam int unsigned ITEMS_PER_PHASE = 50;
    localparam int NO_CHANGE = -1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

    typedef enum int {USE_MODEL, EXPECT_NONE, EXPECT_ONE} t_row_check;

    typedef struct {
        int         cfg_sel;
        t_in_item   item;
        t_row_check check;
        t_out_item  result;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      i_in_valid;
    t_in_item                  i_in_data;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic                      i_out_stall;
    t_out_item                 o_out_data;

    t_cfg        settings;
    t_cfg        presets [3];
    logic [7:0]  btn_pressed;
    logic [7:0]  btn_latched;
    logic [31:0] btn_since [BUTTONS_DEFAULT];
    logic        irq_armed;
    logic [31:0] irq_stamp;

    t_out_item   fresh_events [$];
    t_out_item   awaited_events [$];
    t_out_item   want_event;
    t_row        directed_rows [26];
    logic [31:0] clock_ms;
    logic [7:0]  levels_now;
    int unsigned error_count;

    multi_button_debounce_events dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void clear_model();
        int b;
        settings.debounce_delay    = DEBOUNCE_DELAY_RESET;
        settings.button_count      = '0;
        settings.active_low_mask   = '0;
        settings.action_codes      = '0;
        settings.interrupt_action  = '0;
        settings.interrupt_lockout = INTERRUPT_LOCKOUT_RESET;
        btn_pressed = '0;
        btn_latched = '0;
        for (b = 0; b < BUTTONS_DEFAULT; b++) begin
            btn_since[b] = '0;
        end
        irq_armed = 1'b0;
        irq_stamp = '0;
    endfunction

    task automatic debounce_step(input t_in_item it);
        int          b;
        int unsigned n_btn;
        logic        pressed;
        logic [31:0] held;
        t_out_item   ev;
        fresh_events.delete();
        if (it.opcode == OP_INTERRUPT) begin
            held = it.timestamp - irq_stamp;
            if (held > {16'd0, settings.interrupt_lockout}) begin
                irq_armed = 1'b1;
                irq_stamp = it.timestamp;
            end
            return;
        end
        if (irq_armed) begin
            ev.action_code    = settings.interrupt_action;
            ev.from_interrupt = 1'b1;
            ev.button_index   = '0;
            ev.last_of_run    = 1'b0;
            fresh_events.push_back(ev);
            irq_armed = 1'b0;
        end
        n_btn = (settings.button_count > BUTTONS_DEFAULT) ? BUTTONS_DEFAULT
                                                          : settings.button_count;
        for (b = 0; b < n_btn; b++) begin
            pressed = it.button_levels[b] ^ settings.active_low_mask[b];
            if (pressed != btn_pressed[b]) begin
                btn_since[b] = it.timestamp;
            end
            held = it.timestamp - btn_since[b];
            if (held > {16'd0, settings.debounce_delay}) begin
                if (pressed && !btn_latched[b]) begin
                    ev.action_code    = settings.action_codes[4*b +: 4];
                    ev.from_interrupt = 1'b0;
                    ev.button_index   = 3'(b);
                    ev.last_of_run    = 1'b0;
                    fresh_events.push_back(ev);
                    btn_latched[b] = 1'b1;
                end else if (!pressed) begin
                    btn_latched[b] = 1'b0;
                end
            end
            btn_pressed[b] = pressed;
        end
        if (fresh_events.size() > 0) begin
            fresh_events[fresh_events.size() - 1].last_of_run = 1'b1;
        end
    endtask

    function automatic t_row row(int sel, logic op, logic [31:0] ts, logic [7:0] lv,
                                 t_row_check chk, t_out_item res = '0);
        t_row r;
        r.cfg_sel            = sel;
        r.item.opcode        = op;
        r.item.timestamp     = ts;
        r.item.button_levels = lv;
        r.check              = chk;
        r.result             = res;
        return r;
    endfunction

    function automatic void build_table();
        presets[0] = '{16'd10, 4'd8, 8'h00, 32'h8765_4321, 4'hF, 16'd0};
        presets[1] = '{16'd0, 4'd15, 8'hFF, 32'hFFFF_FFFF, 4'd5, 16'hFFFF};
        presets[2] = '{16'hFFFF, 4'd1, 8'h00, 32'h0000_000A, 4'd0, 16'd0};

        directed_rows[0]  = row(NO_CHANGE, OP_POLL, 32'd0, 8'hFF, EXPECT_NONE);
        directed_rows[1]  = row(NO_CHANGE, OP_INTERRUPT, 32'd100, 8'h00, EXPECT_NONE);
        directed_rows[2]  = row(NO_CHANGE, OP_INTERRUPT, 32'd200, 8'h5A, EXPECT_NONE);
        directed_rows[3]  = row(NO_CHANGE, OP_POLL, 32'd210, 8'h00, EXPECT_NONE);
        directed_rows[4]  = row(NO_CHANGE, OP_INTERRUPT, 32'd201, 8'hA5, EXPECT_NONE);
        directed_rows[5]  = row(NO_CHANGE, OP_INTERRUPT, 32'd300, 8'h00, EXPECT_NONE);
        directed_rows[6]  = row(NO_CHANGE, OP_POLL, 32'd300, 8'h00, EXPECT_ONE,
                                t_out_item'{4'h0, 1'b1, 3'd0, 1'b1});
        directed_rows[7]  = row(0, OP_POLL, 32'd1000, 8'hFF, EXPECT_NONE);
        directed_rows[8]  = row(NO_CHANGE, OP_POLL, 32'd1010, 8'hFF, EXPECT_NONE);
        directed_rows[9]  = row(NO_CHANGE, OP_POLL, 32'd1011, 8'hFF, USE_MODEL);
        directed_rows[10] = row(NO_CHANGE, OP_POLL, 32'd2000, 8'hFF, EXPECT_NONE);
        directed_rows[11] = row(NO_CHANGE, OP_INTERRUPT, 32'd2000, 8'hFF, EXPECT_NONE);
        directed_rows[12] = row(NO_CHANGE, OP_INTERRUPT, 32'd2000, 8'h00, EXPECT_NONE);
        directed_rows[13] = row(NO_CHANGE, OP_POLL, 32'd2000, 8'h00, EXPECT_ONE,
                                t_out_item'{4'hF, 1'b1, 3'd0, 1'b1});
        directed_rows[14] = row(NO_CHANGE, OP_POLL, 32'd2020, 8'h00, EXPECT_NONE);
        directed_rows[15] = row(1, OP_POLL, 32'd2021, 8'h00, EXPECT_NONE);
        directed_rows[16] = row(NO_CHANGE, OP_POLL, 32'd2022, 8'h00, USE_MODEL);
        directed_rows[17] = row(NO_CHANGE, OP_POLL, 32'd2023, 8'hAA, EXPECT_NONE);
        directed_rows[18] = row(NO_CHANGE, OP_INTERRUPT, 32'd2024, 8'h00, EXPECT_NONE);
        directed_rows[19] = row(NO_CHANGE, OP_INTERRUPT, 32'hFFFF_FFFF, 8'hFF, EXPECT_NONE);
        directed_rows[20] = row(NO_CHANGE, OP_POLL, 32'd2024, 8'hAA, EXPECT_ONE,
                                t_out_item'{4'h5, 1'b1, 3'd0, 1'b1});
        directed_rows[21] = row(2, OP_POLL, 32'hFFFF_FFF0, 8'h00, EXPECT_NONE);
        directed_rows[22] = row(NO_CHANGE, OP_POLL, 32'h0000_FFEF, 8'h00, EXPECT_NONE);
        directed_rows[23] = row(NO_CHANGE, OP_POLL, 32'h0000_FFF0, 8'h00, EXPECT_NONE);
        directed_rows[24] = row(NO_CHANGE, OP_POLL, 32'h0000_FFF1, 8'h01, EXPECT_NONE);
        directed_rows[25] = row(NO_CHANGE, OP_POLL, 32'h0001_FFF1, 8'h01, EXPECT_ONE,
                                t_out_item'{4'hA, 1'b0, 3'd0, 1'b1});
    endfunction

    function automatic t_cfg phase_settings(int unsigned p);
        t_cfg s;
        s.debounce_delay    = 16'($urandom_range(0, 120));
        s.button_count      = 4'($urandom_range(0, 15));
        s.active_low_mask   = 8'($urandom);
        s.action_codes      = $urandom;
        s.interrupt_action  = 4'($urandom);
        s.interrupt_lockout = 16'($urandom_range(0, 300));
        case (p)
            0: begin
                s.debounce_delay    = '0;
                s.interrupt_lockout = '0;
                s.button_count      = 4'd8;
            end
            1: begin
                s.debounce_delay    = '1;
                s.interrupt_lockout = '1;
                s.button_count      = 4'd8;
            end
            2: begin
                s.button_count = '0;
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    // Upper bits beyond the register width carry random junk.
    task automatic put_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [31:0] value, input int unsigned width);
        logic [31:0] word;
        word = value;
        if (width < 32) begin
            word = value | ($urandom << width);
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg s);
        put_register(REG_DEBOUNCE_DELAY, {16'd0, s.debounce_delay}, 16);
        put_register(REG_SPARE_A, $urandom, 32);
        put_register(REG_BUTTON_COUNT, {28'd0, s.button_count}, 4);
        put_register(REG_ACTIVE_LOW_MASK, {24'd0, s.active_low_mask}, 8);
        put_register(REG_ACTION_CODES, s.action_codes, 32);
        put_register(REG_INTERRUPT_ACTION, {28'd0, s.interrupt_action}, 4);
        put_register(REG_SPARE_B, $urandom, 32);
        put_register(REG_INTERRUPT_LOCKOUT, {16'd0, s.interrupt_lockout}, 16);
        i_cfg_we <= 1'b0;
        settings = s;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_item(input t_in_item it, input int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        debounce_step(it);
    endtask

    // Levels mostly hold long enough to pass the debounce delay; a few
    // items flip one button, and some inject full random bounce noise.
    task automatic make_random_item(output t_in_item it);
        int unsigned span;
        span = settings.debounce_delay * 2 / 3 + 3;
        if ($urandom_range(0, 99) < 3) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + $urandom_range(0, span);
        end
        if ($urandom_range(0, 3) == 0) begin
            levels_now[$urandom_range(0, 7)] = ~levels_now[$urandom_range(0, 7)];
        end
        if ($urandom_range(0, 19) == 0) begin
            levels_now = 8'($urandom);
        end
        it.opcode        = ($urandom_range(0, 4) == 0) ? OP_INTERRUPT : OP_POLL;
        it.timestamp     = clock_ms;
        it.button_levels = levels_now;
        if (it.opcode == OP_INTERRUPT) begin
            it.button_levels = 8'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                it.timestamp = $urandom;
            end
        end
    endtask

    function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(40, 150)) @(posedge i_clk);
            end else begin
                repeat (1 + pick_gap()) @(posedge i_clk);
            end
            i_out_stall <= 1'b1;
            repeat (1 + pick_gap()) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (awaited_events.size() == 0) begin
                $display("%0t: unexpected result item, expected none, got %h",
                         $time, o_out_data);
                error_count++;
            end else begin
                want_event = awaited_events.pop_front();
                note_field("action_code", want_event.action_code, o_out_data.action_code);
                note_field("from_interrupt", want_event.from_interrupt,
                           o_out_data.from_interrupt);
                note_field("button_index", want_event.button_index, o_out_data.button_index);
                note_field("last_of_run", want_event.last_of_run, o_out_data.last_of_run);
            end
        end
    end

    initial begin
        int unsigned p;
        int unsigned k;
        t_in_item    it;
        error_count = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        clock_ms    = '0;
        levels_now  = '0;
        clear_model();
        build_table();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg_sel != NO_CHANGE) begin
                settle();
                load_settings(presets[directed_rows[r].cfg_sel]);
            end
            send_item(directed_rows[r].item, pick_gap());
            case (directed_rows[r].check)
                USE_MODEL: begin
                    foreach (fresh_events[e]) awaited_events.push_back(fresh_events[e]);
                end
                EXPECT_ONE: begin
                    awaited_events.push_back(directed_rows[r].result);
                end
                default: begin
                end
            endcase
        end

        for (p = 0; p < PHASES; p++) begin
            settle();
            load_settings(phase_settings(p));
            if (p == 4) begin
                clock_ms = 32'hFFFF_0000;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                make_random_item(it);
                send_item(it, (p == 5) ? 0 : pick_gap());
                foreach (fresh_events[e]) awaited_events.push_back(fresh_events[e]);
            end
        end

        settle();
        if (error_count == 0 && awaited_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
